FILE: design/grid_paint_connectivity_union_find_macros.svh
// Assertion macros shared by the grid connectivity design.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GRID_PAINT_CONNECTIVITY_UNION_FIND_MACROS_SVH
`define GRID_PAINT_CONNECTIVITY_UNION_FIND_MACROS_SVH
`ifndef SYNTH
`define GPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/gpc_pkg.sv
// Package for the grid connectivity block: sizes, register indexes, state codes
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package gpc_pkg;
    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int Cells = MaxRows * MaxCols;
    localparam int IdxW = $clog2(Cells);
    localparam int SizeW = IdxW + 1;
    localparam int CfgW = 7;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] RegGridHeight = 1'b0;
    localparam logic [CfgIdxW-1:0] RegGridWidth  = 1'b1;

    localparam logic KindPaint = 1'b0;
    localparam logic KindQuery = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PAINT,
        S_NB_CHECK,
        S_NB_PWAIT,
        S_FIND_INIT,
        S_FIND_RD,
        S_FIND_WAIT,
        S_FIND_STEP,
        S_COMP_RD,
        S_COMP_WAIT,
        S_COMP_STEP,
        S_SIZE_RD,
        S_SIZE_WAIT,
        S_LINK,
        S_Q_PWAIT,
        S_Q_EVAL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_NB
    } t_sel;

    typedef struct packed {
        logic       clear_step;
        logic       load_item;
        logic       paint_write;
        logic       nb_read;
        logic       nb_next;
        logic       find_load;
        t_sel       find_sel;
        logic       find_read;
        logic       find_step;
        logic       comp_read;
        logic       comp_write;
        logic       save_ra;
        logic       size_read;
        logic       link;
        logic       pa_read;
        logic       save_result;
    } t_cmd;

    typedef struct packed {
        logic       clear_done;
        logic       item_in_grid;
        logic       item_is_query;
        logic       nb_valid;
        logic       nb_last;
        logic       nb_painted;
        logic       at_root;
        logic       comp_done;
    } t_status;
endpackage

FILE: design/grid_paint_connectivity_union_find.sv
// Grid paint connectivity: union-find over a 64 x 64 cell grid.
// After reset a clearing pass over all 4096 cells initialises the parent, size
// and paint memories; no request is accepted during it. A request occupies the
// block from acceptance until it finishes. Each parent-memory access is a
// registered read then a wait state: a find walks each link to the root with
// read, wait and step states, then compresses each node on its path with read,
// wait and write states. A paint runs up to four unions (two finds each). A
// query result is held until taken; the next request is accepted after that.
`timescale 1ns / 1ps
module grid_paint_connectivity_union_find
    import gpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [5:0]         i_row_a,
    input  logic [5:0]         i_col_a,
    input  logic [5:0]         i_row_b,
    input  logic [5:0]         i_col_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_connected
);
    t_cmd    cmd;
    t_status status;

    gpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gpc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_kind     (i_kind),
        .i_row_a    (i_row_a),
        .i_col_a    (i_col_a),
        .i_row_b    (i_row_b),
        .i_col_b    (i_col_b),
        .o_status   (status),
        .o_connected(o_connected)
    );
endmodule

FILE: design/gpc_ctrl.sv
// Controller state machine for the grid connectivity block.
// Uses gpc_pkg; drives the datapath by t_cmd and reads t_status.
`timescale 1ns / 1ps
`include "grid_paint_connectivity_union_find_macros.svh"
module gpc_ctrl
    import gpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    // Which find is running: 0 first operand, 1 second operand.
    logic r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        case (r_state)
            S_CLEAR:     if (i_status.clear_done) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) n_state = S_PAINT;
            end
            S_PAINT: begin
                n_second = 1'b0;
                if (!i_status.item_in_grid) begin
                    n_state = i_status.item_is_query ? S_OUT : S_IDLE;
                end else if (i_status.item_is_query) begin
                    n_state = S_FIND_INIT;
                end else begin
                    n_state = S_NB_CHECK;
                end
            end
            S_NB_CHECK: n_state = i_status.nb_valid ? S_NB_PWAIT :
                                  (i_status.nb_last ? S_IDLE : S_NB_CHECK);
            S_NB_PWAIT: begin
                n_second = 1'b0;
                if (i_status.nb_painted) n_state = S_FIND_INIT;
                else n_state = i_status.nb_last ? S_IDLE : S_NB_CHECK;
            end
            S_FIND_INIT: n_state = S_FIND_RD;
            S_FIND_RD:   n_state = S_FIND_WAIT;
            S_FIND_WAIT: n_state = S_FIND_STEP;
            S_FIND_STEP: n_state = i_status.at_root ? S_COMP_RD : S_FIND_RD;
            S_COMP_RD:   n_state = i_status.comp_done ? S_SIZE_RD : S_COMP_WAIT;
            S_COMP_WAIT: n_state = S_COMP_STEP;
            S_COMP_STEP: n_state = S_COMP_RD;
            S_SIZE_RD: begin
                if (!r_second) begin
                    n_second = 1'b1;
                    n_state  = S_FIND_INIT;
                end else if (i_status.item_is_query) begin
                    n_state = S_Q_PWAIT;
                end else begin
                    n_state = S_SIZE_WAIT;
                end
            end
            S_SIZE_WAIT: n_state = S_LINK;
            S_LINK:      n_state = i_status.nb_last ? S_IDLE : S_NB_CHECK;
            S_Q_PWAIT:   n_state = S_Q_EVAL;
            S_Q_EVAL:    n_state = S_OUT;
            S_OUT:       if (i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.find_sel = SEL_A;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_PAINT: o_cmd.paint_write = i_status.item_in_grid &&
                                         !i_status.item_is_query;
            S_NB_CHECK: begin
                o_cmd.nb_read = i_status.nb_valid;
                o_cmd.nb_next = !i_status.nb_valid;
            end
            S_NB_PWAIT: o_cmd.nb_next = !i_status.nb_painted;
            S_FIND_INIT: begin
                o_cmd.find_load = 1'b1;
                if (i_status.item_is_query) o_cmd.find_sel = r_second ? SEL_B : SEL_A;
                else o_cmd.find_sel = r_second ? SEL_NB : SEL_A;
            end
            S_FIND_RD:   o_cmd.find_read = 1'b1;
            S_FIND_STEP: o_cmd.find_step = 1'b1;
            S_COMP_RD:   o_cmd.comp_read = !i_status.comp_done;
            S_COMP_STEP: o_cmd.comp_write = 1'b1;
            S_SIZE_RD: begin
                o_cmd.save_ra   = !r_second;
                o_cmd.size_read = r_second && !i_status.item_is_query;
                o_cmd.pa_read   = r_second && i_status.item_is_query;
            end
            S_LINK: begin
                o_cmd.link    = 1'b1;
                o_cmd.nb_next = 1'b1;
            end
            S_Q_EVAL: o_cmd.save_result = 1'b1;
            S_OUT:    o_out_valid = 1'b1;
            default: ;
        endcase
    end

    `GPC_ASSERT_IMPL(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE, "ready outside idle")
    `GPC_ASSERT_IMPL(a_no_both, i_clk, i_rst_n, o_out_valid, !o_in_ready, "ready while result waits")
    `GPC_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped")
endmodule

FILE: design/gpc_datapath.sv
// Datapath for the grid connectivity block: parent, size and paint memories,
// coordinate logic, find and compression walks. Uses gpc_pkg.
`timescale 1ns / 1ps
`include "grid_paint_connectivity_union_find_macros.svh"
module gpc_datapath
    import gpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_kind,
    input  logic [5:0]         i_row_a,
    input  logic [5:0]         i_col_a,
    input  logic [5:0]         i_row_b,
    input  logic [5:0]         i_col_b,
    output t_status            o_status,
    output logic               o_connected
);
    logic [IdxW-1:0]  mem_parent [Cells];
    logic [SizeW-1:0] mem_size   [Cells];
    logic             mem_paint  [Cells];

    logic [CfgW-1:0] r_height, r_width;
    logic            r_kind;
    logic [5:0]      r_ra, r_ca, r_rb, r_cb;
    logic [1:0]      r_dir;
    logic [IdxW:0]   r_clr;
    logic [IdxW-1:0] r_cur, r_walk, r_root, r_root_a, r_rd_idx;
    logic [IdxW-1:0] r_par_q;
    logic [SizeW-1:0] r_size_q;
    logic [SizeW-1:0] r_size_a;
    logic            r_pa_q, r_pa_a;
    logic            r_conn;

    logic [6:0] h_use, w_use;
    assign h_use = (r_height > 7'(MaxRows)) ? 7'(MaxRows) : r_height;
    assign w_use = (r_width  > 7'(MaxCols)) ? 7'(MaxCols) : r_width;

    // Cell index with the current row stride.
    function automatic logic [IdxW-1:0] cell_idx(input logic [6:0] row,
                                                 input logic [6:0] col,
                                                 input logic [6:0] w);
        logic [13:0] prod;
        begin
            prod = 14'(row) * 14'(w) + 14'(col);
            cell_idx = prod[IdxW-1:0];
        end
    endfunction

    logic [6:0] nb_r, nb_c;
    logic       nb_ok;
    always_comb begin
        nb_r  = {1'b0, r_ra};
        nb_c  = {1'b0, r_ca};
        nb_ok = 1'b0;
        case (r_dir)
            2'd0: begin nb_c = {1'b0, r_ca} + 7'd1; nb_ok = nb_c < w_use; end
            2'd1: begin nb_r = {1'b0, r_ra} + 7'd1; nb_ok = nb_r < h_use; end
            2'd2: begin nb_c = {1'b0, r_ca} - 7'd1; nb_ok = r_ca != 6'd0; end
            default: begin nb_r = {1'b0, r_ra} - 7'd1; nb_ok = r_ra != 6'd0; end
        endcase
    end

    logic [IdxW-1:0] idx_a, idx_b, idx_nb, find_src;
    assign idx_a  = cell_idx({1'b0, r_ra}, {1'b0, r_ca}, w_use);
    assign idx_b  = cell_idx({1'b0, r_rb}, {1'b0, r_cb}, w_use);
    assign idx_nb = cell_idx(nb_r, nb_c, w_use);
    always_comb begin
        case (i_cmd.find_sel)
            SEL_B:   find_src = idx_b;
            SEL_NB:  find_src = idx_nb;
            default: find_src = idx_a;
        endcase
    end

    logic in_grid;
    assign in_grid = ({1'b0, r_ra} < h_use) && ({1'b0, r_ca} < w_use) &&
                     ((r_kind == KindPaint) ||
                      (({1'b0, r_rb} < h_use) && ({1'b0, r_cb} < w_use)));

    // Link: larger set wins, on equal sizes the first root (painted cell) wins.
    logic a_wins, same_root;
    assign same_root = r_root_a == r_root;
    assign a_wins    = !(r_size_a < r_size_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 7'd64;
            r_width  <= 7'd64;
            r_clr    <= '0;
            r_dir    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == RegGridHeight) r_height <= i_cfg_data;
                else r_width <= i_cfg_data;
            end
            if (i_cmd.clear_step && !r_clr[IdxW]) r_clr <= r_clr + 1'b1;
            if (i_cmd.load_item) r_dir <= '0;
            else if (i_cmd.nb_next) r_dir <= r_dir + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind <= i_kind;
            r_ra <= i_row_a; r_ca <= i_col_a; r_rb <= i_row_b; r_cb <= i_col_b;
        end
        if (i_cmd.find_load) begin
            r_cur  <= find_src;
            r_walk <= find_src;
        end
        if (i_cmd.find_read || i_cmd.comp_read) begin
            r_rd_idx <= i_cmd.find_read ? r_cur : r_walk;
            r_par_q  <= mem_parent[i_cmd.find_read ? r_cur : r_walk];
            r_size_q <= mem_size[r_cur];
        end
        if (i_cmd.find_step) begin
            if (r_par_q == r_rd_idx) r_root <= r_rd_idx;
            else r_cur <= r_par_q;
        end
        if (i_cmd.comp_write) r_walk <= r_par_q;
        if (i_cmd.save_ra) begin
            r_root_a <= r_root;
            r_size_a <= r_size_q;
        end
        if (i_cmd.size_read) r_size_q <= mem_size[r_root];
        if (i_cmd.nb_read || i_cmd.pa_read)
            r_pa_q <= mem_paint[i_cmd.nb_read ? idx_nb : idx_b];
        if (i_cmd.pa_read) r_pa_a <= mem_paint[idx_a];
        if (i_cmd.save_result) r_conn <= same_root && r_pa_a && r_pa_q;
        if (!in_grid) r_conn <= 1'b0;
    end

    // Root's size is captured with its parent read; it is valid when at_root.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step && !r_clr[IdxW]) begin
            mem_parent[r_clr[IdxW-1:0]] <= r_clr[IdxW-1:0];
            mem_size[r_clr[IdxW-1:0]]   <= SizeW'(1);
            mem_paint[r_clr[IdxW-1:0]]  <= 1'b0;
        end else if (i_cmd.paint_write) begin
            mem_paint[idx_a] <= 1'b1;
        end else if (i_cmd.comp_write) begin
            mem_parent[r_walk] <= r_root;
        end else if (i_cmd.link && !same_root) begin
            if (a_wins) begin
                mem_parent[r_root] <= r_root_a;
                mem_size[r_root_a] <= r_size_a + r_size_q;
            end else begin
                mem_parent[r_root_a] <= r_root;
                mem_size[r_root]     <= r_size_a + r_size_q;
            end
        end
    end

    assign o_status.clear_done    = r_clr[IdxW];
    assign o_status.item_in_grid  = in_grid;
    assign o_status.item_is_query = r_kind == KindQuery;
    assign o_status.nb_valid      = nb_ok;
    assign o_status.nb_last       = r_dir == 2'd3;
    assign o_status.nb_painted    = r_pa_q;
    assign o_status.at_root       = r_par_q == r_rd_idx;
    assign o_status.comp_done     = r_walk == r_root;
    assign o_connected            = r_conn;

    `GPC_ASSERT_IMPL(a_size_pos, i_clk, i_rst_n, i_cmd.link, r_size_q != '0, "zero set size")
    `GPC_ASSERT_IMPL(a_link_cfg, i_clk, i_rst_n, i_cmd.link, !i_cfg_we, "config during union")
    `GPC_ASSERT_NEXT(a_clear_hold, i_clk, i_rst_n, r_clr[IdxW], r_clr[IdxW], "clear restarted")
endmodule

FILE: tb/grid_paint_connectivity_union_find_test.sv
// Self-checking testbench for the grid paint connectivity block.
// Holds its own union-find predictor; depends only on gpc_pkg and the block itself.
`timescale 1ns / 1ps
module grid_paint_connectivity_union_find_test;
    import gpc_pkg::*;

    typedef struct {
        logic       kind;
        logic [5:0] row_a;
        logic [5:0] col_a;
        logic [5:0] row_b;
        logic [5:0] col_b;
    } t_request;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [CfgW-1:0]    i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_kind;
    logic [5:0]         i_row_a;
    logic [5:0]         i_col_a;
    logic [5:0]         i_row_b;
    logic [5:0]         i_col_b;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_connected;

    grid_paint_connectivity_union_find dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_row_a     (i_row_a),
        .i_col_a     (i_col_a),
        .i_row_b     (i_row_b),
        .i_col_b     (i_col_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_connected (o_connected)
    );

    // Predictor state.
    logic [IdxW-1:0]  cell_link [Cells];
    logic [SizeW-1:0] tree_size [Cells];
    bit               cell_on   [Cells];
    logic [CfgW-1:0]  model_height;
    logic [CfgW-1:0]  model_width;

    t_request pending_requests[$];
    logic     expected_connected[$];

    int  err_count;
    int  paints_sent;
    int  queries_checked;
    bit  req_taken;
    bit  res_taken;
    bit  send_hold;
    bit  idle_enable;
    int  send_gap;
    int  sink_gap;
    int  sink_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Timeout at %0t with %0d results outstanding", $time,
                 expected_connected.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int rows_in_use();
        return (model_height > MaxRows) ? MaxRows : int'(model_height);
    endfunction

    function automatic int cols_in_use();
        return (model_width > MaxCols) ? MaxCols : int'(model_width);
    endfunction

    // Find with full path compression.
    function automatic int root_of(int x);
        int r;
        int nxt;
        r = x;
        while (int'(cell_link[r]) != r) r = int'(cell_link[r]);
        while (x != r) begin
            nxt = int'(cell_link[x]);
            cell_link[x] = IdxW'(r);
            x = nxt;
        end
        return r;
    endfunction

    function automatic void join_cells(int a, int b);
        int ra;
        int rb;
        int t;
        ra = root_of(a);
        rb = root_of(b);
        if (ra == rb) return;
        if (tree_size[ra] < tree_size[rb]) begin
            t = ra;
            ra = rb;
            rb = t;
        end
        cell_link[rb] = IdxW'(ra);
        tree_size[ra] = tree_size[ra] + tree_size[rb];
    endfunction

    function automatic void apply_paint(t_request rq);
        int h;
        int w;
        int n;
        int nr;
        int nc;
        int dr[4];
        int dc[4];
        dr = '{0, 1, 0, -1};
        dc = '{1, 0, -1, 0};
        h = rows_in_use();
        w = cols_in_use();
        if (rq.row_a >= h || rq.col_a >= w) return;
        n = rq.row_a * w + rq.col_a;
        cell_on[n] = 1'b1;
        for (int k = 0; k < 4; k++) begin
            nr = int'(rq.row_a) + dr[k];
            nc = int'(rq.col_a) + dc[k];
            if (nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
            if (cell_on[nr * w + nc]) join_cells(n, nr * w + nc);
        end
    endfunction

    function automatic logic query_connected(t_request rq);
        int h;
        int w;
        int n;
        int m;
        bit same;
        h = rows_in_use();
        w = cols_in_use();
        if (rq.row_a >= h || rq.col_a >= w || rq.row_b >= h || rq.col_b >= w)
            return 1'b0;
        n = rq.row_a * w + rq.col_a;
        m = rq.row_b * w + rq.col_b;
        same = (root_of(n) == root_of(m));
        return same && cell_on[n] && cell_on[m];
    endfunction

    // Prediction on each accepted request, checking on each accepted result.
    always @(posedge i_clk) begin
        t_request rq;
        logic     want;
        req_taken = i_rst_n && i_in_valid && o_in_ready;
        res_taken = i_rst_n && o_out_valid && i_out_ready;
        if (req_taken) begin
            rq.kind = i_kind;
            rq.row_a = i_row_a;
            rq.col_a = i_col_a;
            rq.row_b = i_row_b;
            rq.col_b = i_col_b;
            if (rq.kind == KindPaint) begin
                apply_paint(rq);
                paints_sent++;
            end else begin
                expected_connected.push_back(query_connected(rq));
            end
        end
        if (res_taken) begin
            if (expected_connected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual connected=%0b",
                         $time, o_connected);
                err_count++;
            end else begin
                want = expected_connected.pop_front();
                queries_checked++;
                if (o_connected !== want) begin
                    $display("%0t: connected mismatch, expected %0b, actual %0b",
                             $time, want, o_connected);
                    err_count++;
                end
            end
        end
    end

    // Request driver.
    always @(negedge i_clk) begin
        t_request rq;
        logic     next_valid;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_in_valid || req_taken) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!send_hold && pending_requests.size() > 0) begin
                rq = pending_requests.pop_front();
                i_kind <= rq.kind;
                i_row_a <= rq.row_a;
                i_col_a <= rq.col_a;
                i_row_b <= rq.row_b;
                i_col_b <= rq.col_b;
                next_valid = 1'b1;
                send_gap = idle_enable ? $urandom_range(0, 11) : 0;
            end
        end
        i_in_valid <= next_valid;
    end

    // Result receiver, with its own long hold-off counter.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            if (res_taken) sink_gap = idle_enable ? $urandom_range(0, 11) : 0;
            if (sink_gap > 0) begin
                sink_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == RegGridHeight) model_height = val;
        else model_width = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        // A paint gives no result, so also wait until the block is idle again.
        while (pending_requests.size() > 0 || i_in_valid ||
               expected_connected.size() > 0 || !o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic add_request(logic kind, int ra, int ca, int rb, int cb);
        t_request rq;
        rq.kind = kind;
        rq.row_a = 6'(ra);
        rq.col_a = 6'(ca);
        rq.row_b = 6'(rb);
        rq.col_b = 6'(cb);
        pending_requests.push_back(rq);
    endtask

    function automatic int pick_coord(int span);
        if (span == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
        return $urandom_range(0, (span > 64 ? 64 : span) - 1);
    endfunction

    task automatic random_phase(int h, int w, int count);
        wait_drained();
        write_reg(RegGridHeight, CfgW'(h));
        write_reg(RegGridWidth, CfgW'(w));
        idle_enable = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++) begin
            add_request(($urandom_range(0, 9) < 6) ? KindPaint : KindQuery,
                        pick_coord(h), pick_coord(w), pick_coord(h), pick_coord(w));
        end
    endtask

    initial begin
        err_count = 0;
        paints_sent = 0;
        queries_checked = 0;
        send_hold = 1'b0;
        idle_enable = 1'b1;
        send_gap = 0;
        sink_gap = 0;
        sink_hold_cycles = 0;
        req_taken = 1'b0;
        res_taken = 1'b0;
        for (int i = 0; i < Cells; i++) begin
            cell_link[i] = IdxW'(i);
            tree_size[i] = SizeW'(1);
            cell_on[i] = 1'b0;
        end
        model_height = 7'd64;
        model_width = 7'd64;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = RegGridHeight;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_kind = KindPaint;
        i_row_a = '0;
        i_col_a = '0;
        i_row_b = '0;
        i_col_b = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the full grid: corners, joins, repaint.
        add_request(KindQuery, 0, 0, 0, 0);
        add_request(KindPaint, 0, 0, 0, 0);
        add_request(KindQuery, 0, 0, 0, 0);
        add_request(KindPaint, 0, 1, 0, 0);
        add_request(KindQuery, 0, 0, 0, 1);
        add_request(KindPaint, 63, 63, 0, 0);
        add_request(KindPaint, 62, 63, 0, 0);
        add_request(KindQuery, 63, 63, 62, 63);
        add_request(KindQuery, 0, 0, 63, 63);
        add_request(KindQuery, 0, 0, 1, 0);
        add_request(KindPaint, 0, 0, 0, 0);
        add_request(KindPaint, 1, 1, 0, 0);
        add_request(KindPaint, 1, 0, 0, 0);
        add_request(KindQuery, 1, 1, 0, 1);
        add_request(KindQuery, 63, 0, 0, 63);
        add_request(KindPaint, 63, 0, 0, 0);
        add_request(KindQuery, 63, 0, 63, 0);

        // Small grid: coordinates outside it are ignored or answer zero.
        wait_drained();
        write_reg(RegGridHeight, 7'd3);
        write_reg(RegGridWidth, 7'd5);
        add_request(KindPaint, 63, 2, 0, 0);
        add_request(KindPaint, 2, 63, 0, 0);
        add_request(KindQuery, 0, 0, 63, 63);
        add_request(KindQuery, 2, 4, 2, 4);
        add_request(KindPaint, 2, 4, 0, 0);
        add_request(KindQuery, 2, 4, 2, 4);

        random_phase(8, 8, 120);
        // Hold results back for a long stretch so the block stalls its input.
        wait_drained();
        sink_hold_cycles = 400;
        random_phase(4, 6, 80);
        random_phase(0, 0, 20);
        random_phase(127, 127, 80);
        random_phase(1, 64, 60);
        random_phase(64, 1, 60);
        random_phase(1, 1, 20);
        random_phase(5, 7, 120);

        // Wait until every result is back, then hold the sender off before carrying on.
        wait_drained();
        send_hold = 1'b1;
        repeat (50) @(posedge i_clk);
        send_hold = 1'b0;
        random_phase(64, 64, 120);
        random_phase(16, 12, 120);

        wait_drained();
        $display("Covered %0d paints and %0d checked queries over grids from empty to oversized,",
                 paints_sent, queries_checked);
        $display("with random idling on both sides and long stalls on each.");
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
